// File: hdl/modular_exponentiation_defines.svh
// assertion macros shared by the rtl
`ifndef MODULAR_EXPONENTIATION_DEFINES_SVH
`define MODULAR_EXPONENTIATION_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define MX_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

`define MX_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");

`else

`define MX_ASSERT(lbl, clk, rst_n, prop)

`define MX_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

// File: hdl/modexp_pkg.sv
package modexp_pkg;

    localparam int DATA_W = 31;
    localparam int EXP_W  = 63;
    localparam int CNT_W  = $clog2(DATA_W);

    localparam logic [DATA_W-1:0] MODULUS_RESET = DATA_W'(1000000007);

    typedef struct packed {
        logic busy;
        logic done;
    } t_mm_stat;

endpackage

// File: hdl/modexp_mulmod.sv
// bit-serial modular multiplier, one bit of a per cycle, msb first
// requires b < m; a may be any value
module modexp_mulmod (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [modexp_pkg::DATA_W-1:0]     i_a,
    input  logic [modexp_pkg::DATA_W-1:0]     i_b,
    input  logic [modexp_pkg::DATA_W-1:0]     i_m,
    output modexp_pkg::t_mm_stat              o_stat,
    output logic [modexp_pkg::DATA_W-1:0]     o_result
);
    import modexp_pkg::*;

    localparam logic [CNT_W-1:0] LAST = CNT_W'(DATA_W - 1);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DATA_W-1:0] r_a;
    logic [DATA_W-1:0] r_b;
    logic [DATA_W-1:0] r_r;
    logic [DATA_W-1:0] n_r;

    logic [DATA_W:0] m_ext;
    logic [DATA_W:0] dbl;
    logic [DATA_W:0] dbl_red;
    logic [DATA_W:0] sum;
    logic [DATA_W:0] sum_red;

    // r = 2r + a_bit * b, kept below m with two conditional subtracts
    always_comb begin
        m_ext   = {1'b0, i_m};
        dbl     = {r_r, 1'b0};
        dbl_red = (dbl >= m_ext) ? dbl - m_ext : dbl;
        sum     = dbl_red + (r_a[DATA_W-1] ? {1'b0, r_b} : '0);
        sum_red = (sum >= m_ext) ? sum - m_ext : sum;
        n_r     = sum_red[DATA_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
            r_r <= '0;
        end else if (r_busy) begin
            r_a <= {r_a[DATA_W-2:0], 1'b0};
            r_r <= n_r;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_result    = r_r;

endmodule

// File: hdl/modular_exponentiation.sv
// Computes base_value to the power exponent modulo the modulus register, by
// right-to-left square and multiply. The base is first reduced modulo m in one
// pass of a bit-serial multiplier; then every exponent bit up to the highest set
// one costs one pass of two such multipliers running side by side (square and
// conditional multiply). A modulus below 2 answers 0 with no multiplier pass.
// One item is worked on at a time; a finished result waits in an output
// register while the next item is taken. Write the modulus only while the block
// is idle.
`include "modular_exponentiation_defines.svh"

module modular_exponentiation (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [modexp_pkg::DATA_W-1:0]     i_cfg_wdata,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [modexp_pkg::DATA_W-1:0]     i_base_value,
    input  logic [modexp_pkg::EXP_W-1:0]      i_exponent,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [modexp_pkg::DATA_W-1:0]     o_power_result
);
    import modexp_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PRE  = 3'd1;
    localparam logic [2:0] S_KICK = 3'd2;
    localparam logic [2:0] S_STEP = 3'd3;

    localparam logic [DATA_W-1:0] ONE = DATA_W'(1);
    localparam logic [DATA_W-1:0] TWO = DATA_W'(2);

    logic [2:0]        r_state;
    logic [DATA_W-1:0] r_modulus;
    logic [DATA_W-1:0] r_acc;
    logic [DATA_W-1:0] r_sq;
    logic [EXP_W-1:0]  r_exp;
    logic [DATA_W-1:0] r_out;
    logic              r_out_valid;

    t_mm_stat          mm0_stat;
    t_mm_stat          mm1_stat;
    logic [DATA_W-1:0] mm0_result;
    logic [DATA_W-1:0] mm1_result;
    logic              mm0_start;
    logic              mm1_start;
    logic [DATA_W-1:0] mm0_a;
    logic [DATA_W-1:0] mm0_b;

    logic in_accept;
    logic out_free;
    logic kick_run;
    logic out_load;

    assign o_ready   = (r_state == S_IDLE);
    assign in_accept = i_valid && o_ready;
    assign out_free  = !r_out_valid || i_ready;
    assign kick_run  = (r_state == S_KICK) && (r_exp != '0);
    assign out_load  = (r_state == S_KICK) && (r_exp == '0) && out_free;

    // in idle mm0 reduces the base (base * 1 mod m)
    assign mm0_start = (in_accept && (r_modulus >= TWO)) || kick_run;
    assign mm1_start = kick_run;
    assign mm0_a     = (r_state == S_IDLE) ? i_base_value : r_acc;
    assign mm0_b     = (r_state == S_IDLE) ? ONE : r_sq;

    modexp_mulmod u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mm0_start),
        .i_a      (mm0_a),
        .i_b      (mm0_b),
        .i_m      (r_modulus),
        .o_stat   (mm0_stat),
        .o_result (mm0_result)
    );

    modexp_mulmod u_sqr (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mm1_start),
        .i_a      (r_sq),
        .i_b      (r_sq),
        .i_m      (r_modulus),
        .o_stat   (mm1_stat),
        .o_result (mm1_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= MODULUS_RESET;
        end else if (i_cfg_we) begin
            r_modulus <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        // modulus below 2 skips straight to a zero result
                        r_state <= (r_modulus >= TWO) ? S_PRE : S_KICK;
                    end
                end
                S_PRE: begin
                    if (mm0_stat.done) begin
                        r_state <= S_KICK;
                    end
                end
                S_KICK: begin
                    if (r_exp != '0) begin
                        r_state <= S_STEP;
                    end else if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                S_STEP: begin
                    if (mm1_stat.done) begin
                        r_state <= S_KICK;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    if (r_modulus >= TWO) begin
                        r_exp <= i_exponent;
                        r_acc <= ONE;
                    end else begin
                        r_exp <= '0;
                        r_acc <= '0;
                    end
                end
            end
            S_PRE: begin
                if (mm0_stat.done) begin
                    r_sq <= mm0_result;
                end
            end
            S_KICK: begin
                if ((r_exp == '0) && out_free) begin
                    r_out <= r_acc;
                end
            end
            S_STEP: begin
                if (mm1_stat.done) begin
                    if (r_exp[0]) begin
                        r_acc <= mm0_result;
                    end
                    r_sq  <= mm1_result;
                    r_exp <= r_exp >> 1;
                end
            end
            default: begin
                r_acc <= r_acc;
            end
        endcase
    end

    assign o_valid        = r_out_valid;
    assign o_power_result = r_out;

    `MX_ASSERT(a_units_in_step, i_clk, i_rst_n, (r_state == S_STEP) |-> (mm0_stat == mm1_stat))
    `MX_ASSERT(a_step_unit_live, i_clk, i_rst_n, (r_state == S_STEP) |-> (mm1_stat.busy || mm1_stat.done))
    `MX_ASSERT(a_exp_shift, i_clk, i_rst_n, ((r_state == S_STEP) && mm1_stat.done) |=> (r_exp == ($past(r_exp) >> 1)))
    `MX_NEVER(a_no_start_busy, i_clk, i_rst_n, mm0_start && mm0_stat.busy)

endmodule
